[design/iotpm_pkg.sv]
// ----------------------------------------------------------------------------
// IPv4 octet trie prefix match: shared types and constants
// Request codes, internal operation codes, status codes, slot layout and
// the command that travels from the front end to the lookup engine.
// ----------------------------------------------------------------------------
package iotpm_pkg;

    localparam int ADDR_W = 32;
    localparam int OCT_W  = 3;
    localparam int ID_W   = 16;
    localparam int TAG_W  = 8;
    localparam int REQ_W  = 2;
    localparam int ST_W   = 2;
    localparam int OCTET_BITS = 8;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_BEGIN  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMMIT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_CONFLICT = 2'd1;
    localparam logic [ST_W-1:0] ST_NOMEM    = 2'd2;

    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_RULE  = 2'd1;
    localparam logic [1:0] KIND_CHILD = 2'd2;

    typedef enum logic [2:0] {
        OP_BEGIN,
        OP_INSERT,
        OP_WILD,
        OP_REJECT,
        OP_COMMIT,
        OP_SEARCH
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] address;
        logic [OCT_W-1:0]  octets;
        logic [ID_W-1:0]   rule_id;
        logic [TAG_W-1:0]  tag;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ID_W-1:0]  val;
        logic [TAG_W-1:0] tag;
    } t_slot;

    function automatic logic [OCTET_BITS-1:0] octet_at(input logic [ADDR_W-1:0] a,
                                                       input logic [1:0] lvl);
        logic [OCTET_BITS-1:0] o;
        case (lvl)
            2'd0:    o = a[31:24];
            2'd1:    o = a[23:16];
            2'd2:    o = a[15:8];
            default: o = a[7:0];
        endcase
        return o;
    endfunction

endpackage

[design/iotpm_front.sv]
// ----------------------------------------------------------------------------
// IPv4 octet trie prefix match: request front end
// Unpacks an input beat and sorts it into an engine operation, rejecting
// bad prefix lengths and rule ids before they reach the trie.
// ----------------------------------------------------------------------------
module iotpm_front #(
    parameter longint unsigned RULE_ID_MAX = 65535
) (
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // address, prefix_octets, rule_id, aggregation, zero pad
    input  logic [iotpm_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // req_type
    input  logic [iotpm_pkg::REQ_W-1:0]       i_s_tuser,
    output logic                              o_push,
    input  logic                              i_full,
    output iotpm_pkg::t_cmd                   o_cmd
);
    import iotpm_pkg::*;

    logic [OCT_W-1:0] w_oct;
    logic [ID_W-1:0]  w_id;
    logic             w_bad;

    assign w_oct = i_s_tdata[34:32];
    assign w_id  = i_s_tdata[50:35];
    assign w_bad = (64'(w_id) > 64'(RULE_ID_MAX)) || (w_oct > 3'd4);

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

    always_comb begin
        o_cmd.address = i_s_tdata[31:0];
        o_cmd.octets  = w_oct;
        o_cmd.rule_id = w_id;
        o_cmd.tag     = i_s_tdata[58:51];
        unique case (i_s_tuser)
            REQ_BEGIN:  o_cmd.op = OP_BEGIN;
            REQ_INSERT: begin
                if (w_bad) begin
                    o_cmd.op = OP_REJECT;
                end else if (w_oct == 3'd0) begin
                    o_cmd.op = OP_WILD;
                end else begin
                    o_cmd.op = OP_INSERT;
                end
            end
            REQ_COMMIT: o_cmd.op = OP_COMMIT;
            default:    o_cmd.op = OP_SEARCH;
        endcase
    end

endmodule

[design/iotpm_queue.sv]
// ----------------------------------------------------------------------------
// IPv4 octet trie prefix match: command queue
// Two-entry queue that decouples the front end from the lookup engine.
// ----------------------------------------------------------------------------
module iotpm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  iotpm_pkg::t_cmd i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output iotpm_pkg::t_cmd o_cmd,
    input  logic            i_pop
);
    import iotpm_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

[design/iotpm_back.sv]
// ----------------------------------------------------------------------------
// IPv4 octet trie prefix match: trie engine
// Holds both trie banks in one slot memory and walks it one level per read
// for inserts and searches; sweeps dirty nodes clean on a begin request.
// ----------------------------------------------------------------------------
module iotpm_back #(
    parameter int NODES_PER_BANK = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  iotpm_pkg::t_cmd                   i_q_cmd,
    output logic                              o_pop,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // status, matched, match_rule, match_aggregation, zero pad
    output logic [iotpm_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import iotpm_pkg::*;

    localparam int NB    = (NODES_PER_BANK > 1) ? $clog2(NODES_PER_BANK) : 1;
    localparam int NU_W  = $clog2(NODES_PER_BANK + 1);
    localparam int AW    = 1 + NB + OCTET_BITS;
    localparam int DEPTH = 1 << AW;
    localparam logic [NB+OCTET_BITS-1:0] BANK_LAST =
        {NB'(NODES_PER_BANK - 1), {OCTET_BITS{1'b1}}};
    localparam logic [AW-1:0] INIT_LAST = {1'b1, BANK_LAST};

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EV   = 3'd3;
    localparam logic [2:0] S_CLR  = 3'd4;

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    logic [2:0]      r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic [NB-1:0]   r_node, n_node;
    logic [1:0]      r_lvl, n_lvl;
    logic [AW-1:0]   r_clr, n_clr;
    logic [NU_W-1:0] r_used [2];
    logic [NU_W-1:0] n_used [2];
    logic            r_sbank, n_sbank;
    logic            r_lbank, n_lbank;
    logic [1:0]      r_ma_flag, n_ma_flag;
    logic [ID_W-1:0] r_ma_rule [2];
    logic [ID_W-1:0] n_ma_rule [2];
    logic [TAG_W-1:0] r_ma_tag [2];
    logic [TAG_W-1:0] n_ma_tag [2];
    logic            r_out_valid, n_out_valid;
    logic [ST_W-1:0] r_out_st, n_out_st;
    logic            r_out_hit, n_out_hit;
    logic [ID_W-1:0] r_out_rule, n_out_rule;
    logic [TAG_W-1:0] r_out_tag, n_out_tag;

    logic            w_bank;
    logic [AW-1:0]   w_raddr;
    logic [AW-1:0]   w_waddr;
    t_slot           w_wdata;
    logic            w_we;
    logic            w_fin;
    logic [ST_W-1:0] w_st;
    logic            w_hit;
    logic [ID_W-1:0] w_rule;
    logic [TAG_W-1:0] w_tag;
    logic            w_last;
    logic            w_child_ok;

    assign w_bank  = (r_cmd.op == OP_SEARCH) ? r_sbank : r_lbank;
    assign w_raddr = {w_bank, r_node, octet_at(r_cmd.address, r_lvl)};
    assign w_last  = (3'({1'b0, r_lvl}) + 3'd1) == r_cmd.octets;
    assign w_child_ok = 32'(r_rdata.val) < 32'(NODES_PER_BANK);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_node      = r_node;
        n_lvl       = r_lvl;
        n_clr       = r_clr;
        n_used      = r_used;
        n_sbank     = r_sbank;
        n_lbank     = r_lbank;
        n_ma_flag   = r_ma_flag;
        n_ma_rule   = r_ma_rule;
        n_ma_tag    = r_ma_tag;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_st    = r_out_st;
        n_out_hit   = r_out_hit;
        n_out_rule  = r_out_rule;
        n_out_tag   = r_out_tag;
        w_we        = 1'b0;
        w_waddr     = r_clr;
        w_wdata     = '0;
        o_pop       = 1'b0;
        w_fin       = 1'b0;
        w_st        = ST_OK;
        w_hit       = 1'b0;
        w_rule      = '0;
        w_tag       = '0;

        unique case (r_state)
            S_INIT: begin
                w_we = 1'b1;
                if (r_clr == INIT_LAST) begin
                    n_state = S_IDLE;
                end else if (r_clr[NB+OCTET_BITS-1:0] == BANK_LAST) begin
                    n_clr = {1'b1, {(NB + OCTET_BITS){1'b0}}};
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_q_cmd;
                    n_node = '0;
                    n_lvl  = 2'd0;
                    case (i_q_cmd.op)
                        OP_BEGIN: begin
                            n_lbank = ~r_lbank;
                            n_clr   = {~r_lbank, {(NB + OCTET_BITS){1'b0}}};
                            n_state = S_CLR;
                        end
                        OP_COMMIT: begin
                            n_sbank = r_lbank;
                            w_fin   = 1'b1;
                        end
                        OP_WILD: begin
                            n_ma_flag[r_lbank] = 1'b1;
                            n_ma_rule[r_lbank] = i_q_cmd.rule_id;
                            n_ma_tag[r_lbank]  = i_q_cmd.tag;
                            w_fin = 1'b1;
                        end
                        OP_REJECT: begin
                            w_st  = ST_CONFLICT;
                            w_fin = 1'b1;
                        end
                        OP_SEARCH: begin
                            if (r_ma_flag[r_sbank]) begin
                                w_hit  = 1'b1;
                                w_rule = r_ma_rule[r_sbank];
                                w_tag  = r_ma_tag[r_sbank];
                                w_fin  = 1'b1;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        OP_INSERT: n_state = S_RD;
                        default:   w_fin = 1'b1;
                    endcase
                end
            end
            S_CLR: begin
                w_we = 1'b1;
                if ((NU_W'(r_clr[NB+OCTET_BITS-1:OCTET_BITS]) == r_used[r_lbank] - NU_W'(1))
                    && (r_clr[OCTET_BITS-1:0] == {OCTET_BITS{1'b1}})) begin
                    n_used[r_lbank]    = NU_W'(1);
                    n_ma_flag[r_lbank] = 1'b0;
                    n_ma_rule[r_lbank] = '0;
                    n_ma_tag[r_lbank]  = '0;
                    w_fin = 1'b1;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                w_waddr = w_raddr;
                if (r_cmd.op == OP_SEARCH) begin
                    if (r_rdata.kind == KIND_RULE) begin
                        w_hit  = 1'b1;
                        w_rule = r_rdata.val;
                        w_tag  = r_rdata.tag;
                        w_fin  = 1'b1;
                    end else if (r_rdata.kind == KIND_CHILD && r_lvl != 2'd3 && w_child_ok) begin
                        n_node  = r_rdata.val[NB-1:0];
                        n_lvl   = r_lvl + 2'd1;
                        n_state = S_RD;
                    end else begin
                        w_fin = 1'b1;
                    end
                end else if (r_rdata.kind == KIND_RULE) begin
                    w_st  = ST_CONFLICT;
                    w_fin = 1'b1;
                end else if (w_last) begin
                    w_we         = 1'b1;
                    w_wdata.kind = KIND_RULE;
                    w_wdata.val  = r_cmd.rule_id;
                    w_wdata.tag  = r_cmd.tag;
                    w_fin        = 1'b1;
                end else if (r_rdata.kind == KIND_CHILD) begin
                    if (w_child_ok) begin
                        n_node  = r_rdata.val[NB-1:0];
                        n_lvl   = r_lvl + 2'd1;
                        n_state = S_RD;
                    end else begin
                        w_st  = ST_CONFLICT;
                        w_fin = 1'b1;
                    end
                end else if (32'(r_used[r_lbank]) >= 32'(NODES_PER_BANK)) begin
                    w_st  = ST_NOMEM;
                    w_fin = 1'b1;
                end else begin
                    w_we            = 1'b1;
                    w_wdata.kind    = KIND_CHILD;
                    w_wdata.val     = ID_W'(r_used[r_lbank]);
                    n_used[r_lbank] = r_used[r_lbank] + NU_W'(1);
                    n_node          = r_used[r_lbank][NB-1:0];
                    n_lvl           = r_lvl + 2'd1;
                    n_state         = S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (w_fin) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_out_st    = w_st;
            n_out_hit   = w_hit;
            n_out_rule  = w_rule;
            n_out_tag   = w_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_node     <= n_node;
        r_lvl      <= n_lvl;
        r_out_st   <= n_out_st;
        r_out_hit  <= n_out_hit;
        r_out_rule <= n_out_rule;
        r_out_tag  <= n_out_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr       <= '0;
            r_used[0]   <= NU_W'(1);
            r_used[1]   <= NU_W'(1);
            r_sbank     <= 1'b0;
            r_lbank     <= 1'b0;
            r_ma_flag   <= 2'b00;
            r_ma_rule[0] <= '0;
            r_ma_rule[1] <= '0;
            r_ma_tag[0] <= '0;
            r_ma_tag[1] <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_used      <= n_used;
            r_sbank     <= n_sbank;
            r_lbank     <= n_lbank;
            r_ma_flag   <= n_ma_flag;
            r_ma_rule   <= n_ma_rule;
            r_ma_tag    <= n_ma_tag;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_tag, r_out_rule, r_out_hit, r_out_st};

endmodule

[design/ipv4_octet_trie_prefix_match.sv]
// ----------------------------------------------------------------------------
// IPv4 octet trie prefix match
// Double-buffered prefix rule table kept as a four-level trie with
// one 256-slot node level per address octet.
// ----------------------------------------------------------------------------
// Requests arrive as beats on the slave stream: tuser carries the request
// type and tdata the address, prefix length, rule id and tag. Every request
// gives exactly one result beat on the master stream with status, match flag,
// rule id and tag.
// After reset the block sweeps the slots of all nodes of both banks clean;
// requests queue up but are not served until the sweep ends.
// A search or insert that walks the trie first takes the request, then spends
// a registered slot memory read and its evaluation on each trie level,
// through one memory port.
// A commit, match-all insert, rejected insert or a search answered by the
// match-all rule is answered as the request is taken. A begin request sweeps
// all 256 slots of each node the spare bank has used.
// A two-entry queue takes new requests while the engine works, and the
// result register holds a beat until the receiver takes it; the engine
// starts its next request only once that register is free.
// ----------------------------------------------------------------------------
module ipv4_octet_trie_prefix_match #(
    parameter int              NODES_PER_BANK = 1024,
    parameter longint unsigned RULE_ID_MAX    = 65535
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // address, prefix_octets, rule_id, aggregation, zero pad
    input  logic [iotpm_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // req_type
    input  logic [iotpm_pkg::REQ_W-1:0]       i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // status, matched, match_rule, match_aggregation, zero pad
    output logic [iotpm_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import iotpm_pkg::*;

    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_pop;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    iotpm_front #(
        .RULE_ID_MAX(RULE_ID_MAX)
    ) u_front (
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_push    (w_push),
        .i_full    (w_full),
        .o_cmd     (w_cmd_in)
    );

    iotpm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_cmd_in),
        .o_full (w_full),
        .o_valid(w_q_valid),
        .o_cmd  (w_cmd_out),
        .i_pop  (w_pop)
    );

    iotpm_back #(
        .NODES_PER_BANK(NODES_PER_BANK)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_cmd_out),
        .o_pop     (w_pop),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] != 2'd3))
        else $error("Result beat carries an undefined status code.");

    a_hit_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[2]) |-> (o_m_tdata[1:0] == ST_OK))
        else $error("A search hit carries a non-zero status.");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[2]) |-> (o_m_tdata[26:3] == 24'd0))
        else $error("A result without a hit carries a rule id or tag.");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("The engine took a request from an empty queue.");

endmodule
